// File: sv/dcss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcss_pkg
// shared types, phase codes, register indexes and reset values for the
// drive soft stop controller
// ----------------------------------------------------------------------------
package dcss_pkg;

   localparam int POWER_WIDTH_DEFAULT = 8;

   localparam int DIR_W      = 2;
   localparam int POWER_W    = 8;
   localparam int HOLD_W     = 8;
   localparam int INTERVAL_W = 16;
   localparam int HALVINGS_W = 3;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
   localparam logic [PHASE_W-1:0] PH_MOVING   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_STOPPING = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_HALVINGS = 1'd1;

   localparam logic [INTERVAL_W-1:0] STOP_INTERVAL_RESET = 16'd100;
   localparam logic [HALVINGS_W-1:0] STOP_HALVINGS_RESET = 3'd3;

   localparam logic           MODE_COMMAND = 1'b0;
   localparam logic           MODE_TICK    = 1'b1;
   localparam logic [DIR_W-1:0] DIR_IDLE   = 2'd0;

   typedef struct packed {
      logic [DIR_W-1:0]   drive_horiz_dir;
      logic [POWER_W-1:0] drive_horiz_power;
      logic [DIR_W-1:0]   drive_vert_dir;
      logic [POWER_W-1:0] drive_vert_power;
      logic [PHASE_W-1:0] motion_phase;
   } rsp_type;

endpackage

// File: sv/dcss_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcss channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface dcss_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [dcss_pkg::DIR_W-1:0]   horiz_dir;
   logic [dcss_pkg::POWER_W-1:0] horiz_power;
   logic [dcss_pkg::DIR_W-1:0]   vert_dir;
   logic [dcss_pkg::POWER_W-1:0] vert_power;
   logic [dcss_pkg::HOLD_W-1:0]  hold_ticks;

   modport source (output valid, mode, horiz_dir, horiz_power, vert_dir, vert_power,
                   hold_ticks, input ready);
   modport sink (input valid, mode, horiz_dir, horiz_power, vert_dir, vert_power,
                 hold_ticks, output ready);
endinterface

interface dcss_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dcss_pkg::DIR_W-1:0]   drive_horiz_dir;
   logic [dcss_pkg::POWER_W-1:0] drive_horiz_power;
   logic [dcss_pkg::DIR_W-1:0]   drive_vert_dir;
   logic [dcss_pkg::POWER_W-1:0] drive_vert_power;
   logic [dcss_pkg::PHASE_W-1:0] motion_phase;

   modport source (output valid, drive_horiz_dir, drive_horiz_power, drive_vert_dir,
                   drive_vert_power, motion_phase, input ready);
   modport sink (input valid, drive_horiz_dir, drive_horiz_power, drive_vert_dir,
                 drive_vert_power, motion_phase, output ready);
endinterface

interface dcss_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dcss_pkg::CSR_IDX_W-1:0]  index;
   logic [dcss_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/drive_command_soft_stop_fsm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_command_soft_stop_fsm_unit
// idle / moving / soft stop controller for a two-axis drive with watchdog
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_chan  in         valid/ready        mode, dirs, powers, hold_ticks
//  rsp_chan  out        valid/ready        drive dirs, drive powers, phase
//  csr_chan  in         valid/ready        index, data
//
//  one request per cycle while req ready is high; a result enters the output buffer on acceptance
//  two-entry output buffer: requests keep flowing while a result waits
//  req ready drops only when both output entries are full or in reset
//  synchronous active-high reset: phase idle, held values and counters zero
// ----------------------------------------------------------------------------
module drive_command_soft_stop_fsm_unit #(
   parameter int POWER_WIDTH = dcss_pkg::POWER_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dcss_req_if.sink   req_chan,
   dcss_rsp_if.source rsp_chan,
   dcss_csr_if.sink   csr_chan
);

   logic [dcss_pkg::INTERVAL_W-1:0] interval_ff;
   logic [dcss_pkg::HALVINGS_W-1:0] halvings_ff;

   logic [dcss_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [dcss_pkg::DIR_W-1:0]      hdir_ff, hdir_in, vdir_ff, vdir_in;
   logic [POWER_WIDTH-1:0]          hpow_ff, hpow_in, vpow_ff, vpow_in;
   logic [dcss_pkg::HALVINGS_W-1:0] hcount_ff, hcount_in;
   logic [dcss_pkg::INTERVAL_W-1:0] stick_ff, stick_in;
   logic                            wd_armed_ff, wd_armed_in;
   logic [dcss_pkg::HOLD_W-1:0]     wd_count_ff, wd_count_in;
   logic [dcss_pkg::HOLD_W-1:0]     wd_period_ff, wd_period_in;

   dcss_pkg::rsp_type out_data_ff, out_data_in, skid_data_ff, skid_data_in, new_rsp;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept, emit, same, stop_from_idle;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !skid_valid_ff && !reset;
   assign csr_chan.ready = !reset;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= dcss_pkg::STOP_INTERVAL_RESET;
         halvings_ff <= dcss_pkg::STOP_HALVINGS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            dcss_pkg::CSR_STOP_INTERVAL: interval_ff <= csr_chan.data;
            dcss_pkg::CSR_STOP_HALVINGS:
               halvings_ff <= csr_chan.data[dcss_pkg::HALVINGS_W-1:0];
            default: ;
         endcase
      end
   end

   assign same = (req_chan.horiz_dir == hdir_ff) && (req_chan.vert_dir == vdir_ff);
   assign stop_from_idle = 1'b0;

   // update of the drive state for one request
   always_comb begin
      phase_in     = phase_ff;
      hdir_in      = hdir_ff;
      vdir_in      = vdir_ff;
      hpow_in      = hpow_ff;
      vpow_in      = vpow_ff;
      hcount_in    = hcount_ff;
      stick_in     = stick_ff;
      wd_armed_in  = wd_armed_ff;
      wd_count_in  = wd_count_ff;
      wd_period_in = wd_period_ff;
      emit         = 1'b0;

      if (accept) begin
         if (req_chan.mode == dcss_pkg::MODE_COMMAND) begin
            if ((phase_ff == dcss_pkg::PH_IDLE &&
                 !(req_chan.horiz_dir == dcss_pkg::DIR_IDLE &&
                   req_chan.vert_dir == dcss_pkg::DIR_IDLE)) ||
                (phase_ff != dcss_pkg::PH_IDLE && same)) begin
               // drive the command
               emit    = 1'b1;
               hdir_in = req_chan.horiz_dir;
               vdir_in = req_chan.vert_dir;
               hpow_in = POWER_WIDTH'(req_chan.horiz_power);
               vpow_in = POWER_WIDTH'(req_chan.vert_power);
               if (!wd_armed_ff) begin
                  wd_armed_in  = 1'b1;
                  wd_period_in = req_chan.hold_ticks;
               end
               wd_count_in = '0;
               phase_in    = dcss_pkg::PH_MOVING;
            end else if (phase_ff == dcss_pkg::PH_MOVING) begin
               // direction change starts a soft stop
               emit        = 1'b1;
               wd_armed_in = 1'b0;
               wd_count_in = '0;
               stick_in    = '0;
               if (halvings_ff == '0) begin
                  hdir_in   = '0;
                  vdir_in   = '0;
                  hpow_in   = '0;
                  vpow_in   = '0;
                  hcount_in = '0;
                  phase_in  = dcss_pkg::PH_IDLE;
               end else begin
                  hpow_in   = hpow_ff >> 1;
                  vpow_in   = vpow_ff >> 1;
                  hcount_in = dcss_pkg::HALVINGS_W'(1);
                  phase_in  = dcss_pkg::PH_STOPPING;
               end
            end
         end else begin
            if (wd_armed_ff && ({1'b0, wd_count_ff} + 9'd1 >= {1'b0, wd_period_ff})) begin
               wd_armed_in = 1'b0;
               wd_count_in = '0;
            end else if (wd_armed_ff) begin
               wd_count_in = wd_count_ff + 1'b1;
            end

            if (wd_armed_ff && ({1'b0, wd_count_ff} + 9'd1 >= {1'b0, wd_period_ff}) &&
                phase_ff == dcss_pkg::PH_MOVING) begin
               // watchdog expiry starts a soft stop
               emit     = 1'b1;
               stick_in = '0;
               if (halvings_ff == '0) begin
                  hdir_in   = '0;
                  vdir_in   = '0;
                  hpow_in   = '0;
                  vpow_in   = '0;
                  hcount_in = '0;
                  phase_in  = dcss_pkg::PH_IDLE;
               end else begin
                  hpow_in   = hpow_ff >> 1;
                  vpow_in   = vpow_ff >> 1;
                  hcount_in = dcss_pkg::HALVINGS_W'(1);
                  phase_in  = dcss_pkg::PH_STOPPING;
               end
            end else if (phase_ff == dcss_pkg::PH_STOPPING) begin
               if ({1'b0, stick_ff} + 17'd1 >= {1'b0, interval_ff}) begin
                  // stop interval elapsed
                  emit     = 1'b1;
                  stick_in = '0;
                  if (hcount_ff >= halvings_ff) begin
                     hdir_in  = '0;
                     vdir_in  = '0;
                     hpow_in  = '0;
                     vpow_in  = '0;
                     phase_in = dcss_pkg::PH_IDLE;
                  end else begin
                     hpow_in   = hpow_ff >> 1;
                     vpow_in   = vpow_ff >> 1;
                     hcount_in = hcount_ff + 1'b1;
                  end
               end else begin
                  stick_in = stick_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      new_rsp.drive_horiz_dir   = hdir_in;
      new_rsp.drive_horiz_power = dcss_pkg::POWER_W'(hpow_in);
      new_rsp.drive_vert_dir    = vdir_in;
      new_rsp.drive_vert_power  = dcss_pkg::POWER_W'(vpow_in);
      new_rsp.motion_phase      = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dcss_pkg::PH_IDLE;
         hdir_ff     <= '0;
         vdir_ff     <= '0;
         hpow_ff     <= '0;
         vpow_ff     <= '0;
         hcount_ff   <= '0;
         stick_ff    <= '0;
         wd_armed_ff <= 1'b0;
         wd_count_ff <= '0;
         wd_period_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         hdir_ff     <= hdir_in;
         vdir_ff     <= vdir_in;
         hpow_ff     <= hpow_in;
         vpow_ff     <= vpow_in;
         hcount_ff   <= hcount_in;
         stick_ff    <= stick_in;
         wd_armed_ff <= wd_armed_in;
         wd_count_ff <= wd_count_in;
         wd_period_ff <= wd_period_in;
      end
   end

   // two-entry output buffer
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (emit && !stop_from_idle) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = new_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.drive_horiz_dir   = out_data_ff.drive_horiz_dir;
   assign rsp_chan.drive_horiz_power = out_data_ff.drive_horiz_power;
   assign rsp_chan.drive_vert_dir    = out_data_ff.drive_vert_dir;
   assign rsp_chan.drive_vert_power  = out_data_ff.drive_vert_power;
   assign rsp_chan.motion_phase      = out_data_ff.motion_phase;

endmodule

// File: sv/dcss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcss_checker
// port-level checks on the drive soft stop controller results
// ----------------------------------------------------------------------------
module dcss_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dcss_pkg::DIR_W-1:0]   rsp_hdir,
   input logic [dcss_pkg::POWER_W-1:0] rsp_hpow,
   input logic [dcss_pkg::DIR_W-1:0]   rsp_vdir,
   input logic [dcss_pkg::POWER_W-1:0] rsp_vpow,
   input logic [dcss_pkg::PHASE_W-1:0] rsp_phase
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hdir) && $stable(rsp_hpow) &&
         $stable(rsp_vdir) && $stable(rsp_vpow) && $stable(rsp_phase))
      else $error("response changed while stalled");

   // a result in idle is always the zero-power stop
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == dcss_pkg::PH_IDLE |->
         rsp_hdir == '0 && rsp_vdir == '0 && rsp_hpow == '0 && rsp_vpow == '0)
      else $error("idle result with nonzero drive");

   // moving always drives some direction
   a_moving_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == dcss_pkg::PH_MOVING |->
         rsp_hdir != dcss_pkg::DIR_IDLE || rsp_vdir != dcss_pkg::DIR_IDLE)
      else $error("moving result with both directions idle");

   // stopping keeps the directions of the move
   a_stop_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == dcss_pkg::PH_STOPPING |->
         rsp_hdir != dcss_pkg::DIR_IDLE || rsp_vdir != dcss_pkg::DIR_IDLE)
      else $error("stopping result with both directions idle");

endmodule

bind drive_command_soft_stop_fsm_unit dcss_checker u_dcss_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hdir  (rsp_chan.drive_horiz_dir),
   .rsp_hpow  (rsp_chan.drive_horiz_power),
   .rsp_vdir  (rsp_chan.drive_vert_dir),
   .rsp_vpow  (rsp_chan.drive_vert_power),
   .rsp_phase (rsp_chan.motion_phase)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-axis drive soft stop controller. Commands
// and ticks go in through the request channel. An in-bench model of the
// idle, moving and stopping behavior, with its watchdog, predicts every drive
// update. Each update from the block is checked field by field in order.
// Directed cases cover the register extremes, then random traffic runs under
// several stop settings with idle gaps and back pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      logic                         mode;
      logic [dcss_pkg::DIR_W-1:0]   horiz_dir;
      logic [dcss_pkg::POWER_W-1:0] horiz_power;
      logic [dcss_pkg::DIR_W-1:0]   vert_dir;
      logic [dcss_pkg::POWER_W-1:0] vert_power;
      logic [dcss_pkg::HOLD_W-1:0]  hold_ticks;
   } drive_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dcss_req_if req_if();
   dcss_rsp_if rsp_if();
   dcss_csr_if csr_if();

   drive_command_soft_stop_fsm_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // drive model state and register shadows
   logic [dcss_pkg::PHASE_W-1:0]    motion_state;
   logic [dcss_pkg::DIR_W-1:0]      held_hdir;
   logic [dcss_pkg::POWER_W-1:0]    held_hpow;
   logic [dcss_pkg::DIR_W-1:0]      held_vdir;
   logic [dcss_pkg::POWER_W-1:0]    held_vpow;
   logic [dcss_pkg::HALVINGS_W-1:0] halvings_done;
   logic [dcss_pkg::INTERVAL_W-1:0] interval_count;
   logic                            wd_armed;
   logic [dcss_pkg::HOLD_W-1:0]     wd_count;
   logic [dcss_pkg::HOLD_W-1:0]     wd_period;
   logic [dcss_pkg::INTERVAL_W-1:0] cfg_interval;
   logic [dcss_pkg::HALVINGS_W-1:0] cfg_halvings;

   dcss_pkg::rsp_type pending_updates[$];
   dcss_pkg::rsp_type next_update;

   int  failures = 0;
   int  updates_checked = 0;
   int  requests_sent = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   int  rsp_hold_request = 0;
   bit  idling_on = 1'b1;
   bit  req_offered = 1'b0;
   logic [dcss_pkg::DIR_W-1:0] cur_hdir = 2'd1;
   logic [dcss_pkg::DIR_W-1:0] cur_vdir = 2'd1;

   function automatic void stop_interval_elapsed();
      if (halvings_done >= cfg_halvings) begin
         held_hdir    = dcss_pkg::DIR_IDLE;
         held_hpow    = '0;
         held_vdir    = dcss_pkg::DIR_IDLE;
         held_vpow    = '0;
         motion_state = dcss_pkg::PH_IDLE;
      end else begin
         held_hpow     = held_hpow >> 1;
         held_vpow     = held_vpow >> 1;
         halvings_done = halvings_done + 1'b1;
      end
   endfunction

   function automatic void start_soft_stop();
      motion_state   = dcss_pkg::PH_STOPPING;
      halvings_done  = '0;
      interval_count = '0;
      stop_interval_elapsed();
   endfunction

   function automatic void apply_command(input drive_req_type r);
      held_hdir = r.horiz_dir;
      held_hpow = r.horiz_power;
      held_vdir = r.vert_dir;
      held_vpow = r.vert_power;
      // a running watchdog keeps the period it was armed with
      if (!wd_armed) begin
         wd_armed  = 1'b1;
         wd_period = r.hold_ticks;
      end
      wd_count     = '0;
      motion_state = dcss_pkg::PH_MOVING;
   endfunction

   function automatic bit predict_drive_update(input drive_req_type r,
                                               output dcss_pkg::rsp_type upd);
      bit same_dirs;
      bit produced;
      same_dirs = (r.horiz_dir == held_hdir) && (r.vert_dir == held_vdir);
      produced  = 1'b0;
      if (r.mode == dcss_pkg::MODE_COMMAND) begin
         case (motion_state)
            dcss_pkg::PH_IDLE: begin
               if (r.horiz_dir != dcss_pkg::DIR_IDLE || r.vert_dir != dcss_pkg::DIR_IDLE) begin
                  apply_command(r);
                  produced = 1'b1;
               end
            end
            dcss_pkg::PH_MOVING: begin
               produced = 1'b1;
               if (same_dirs) begin
                  apply_command(r);
               end else begin
                  start_soft_stop();
                  wd_armed = 1'b0;
                  wd_count = '0;
               end
            end
            default: begin
               if (same_dirs) begin
                  apply_command(r);
                  produced = 1'b1;
               end
            end
         endcase
      end else begin
         if (wd_armed) begin
            if (int'(wd_count) + 1 >= int'(wd_period)) begin
               wd_armed = 1'b0;
               wd_count = '0;
               if (motion_state == dcss_pkg::PH_MOVING) begin
                  start_soft_stop();
                  produced = 1'b1;
               end
            end else begin
               wd_count = wd_count + 1'b1;
            end
         end
         // expiry that starts a stop ends the tick
         if (!produced && motion_state == dcss_pkg::PH_STOPPING) begin
            if (int'(interval_count) + 1 >= int'(cfg_interval)) begin
               interval_count = '0;
               stop_interval_elapsed();
               produced = 1'b1;
            end else begin
               interval_count = interval_count + 1'b1;
            end
         end
      end
      upd.drive_horiz_dir   = held_hdir;
      upd.drive_horiz_power = held_hpow;
      upd.drive_vert_dir    = held_vdir;
      upd.drive_vert_power  = held_vpow;
      upd.motion_phase      = motion_state;
      return produced;
   endfunction

   function automatic drive_req_type random_request();
      drive_req_type r;
      r.mode        = 1'($urandom);
      r.horiz_dir   = 2'($urandom);
      r.horiz_power = 8'($urandom);
      r.vert_dir    = 2'($urandom);
      r.vert_power  = 8'($urandom);
      r.hold_ticks  = 8'($urandom);
      return r;
   endfunction

   function automatic drive_req_type tick_req();
      drive_req_type r;
      r      = random_request();
      r.mode = dcss_pkg::MODE_TICK;
      return r;
   endfunction

   function automatic drive_req_type command_req(input logic [dcss_pkg::DIR_W-1:0] hd,
                                                 input logic [dcss_pkg::POWER_W-1:0] hp,
                                                 input logic [dcss_pkg::DIR_W-1:0] vd,
                                                 input logic [dcss_pkg::POWER_W-1:0] vp,
                                                 input logic [dcss_pkg::HOLD_W-1:0] hold);
      drive_req_type r;
      r.mode        = dcss_pkg::MODE_COMMAND;
      r.horiz_dir   = hd;
      r.horiz_power = hp;
      r.vert_dir    = vd;
      r.vert_power  = vp;
      r.hold_ticks  = hold;
      return r;
   endfunction

   task automatic send_request(input drive_req_type r);
      dcss_pkg::rsp_type upd;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         if (req_offered) begin
            req_if.valid <= 1'b0;
            req_offered = 1'b0;
         end
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= r.mode;
      req_if.horiz_dir   <= r.horiz_dir;
      req_if.horiz_power <= r.horiz_power;
      req_if.vert_dir    <= r.vert_dir;
      req_if.vert_power  <= r.vert_power;
      req_if.hold_ticks  <= r.hold_ticks;
      req_offered = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      if (predict_drive_update(r, upd))
         pending_updates.push_back(upd);
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      if (req_offered) begin
         req_if.valid <= 1'b0;
         req_offered = 1'b0;
         @(posedge clock);
      end
      while (pending_updates.size() != 0) @(posedge clock);
   endtask

   task automatic set_stop_config(input logic [dcss_pkg::INTERVAL_W-1:0] interval,
                                  input logic [dcss_pkg::HALVINGS_W-1:0] halvings);
      wait_for_drain();
      // ticks leave no update behind, so give them time to retire
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= dcss_pkg::CSR_STOP_INTERVAL;
      csr_if.data  <= dcss_pkg::CSR_DATA_W'(interval);
      do @(posedge clock); while (!csr_if.ready);
      cfg_interval = interval;
      csr_if.index <= dcss_pkg::CSR_STOP_HALVINGS;
      csr_if.data  <= dcss_pkg::CSR_DATA_W'(halvings);
      do @(posedge clock); while (!csr_if.ready);
      cfg_halvings = halvings;
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic void check_field(input string name, input logic [7:0] expv,
                                       input logic [7:0] actv);
      if (actv !== expv) begin
         $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
         failures++;
      end
   endfunction

   // drive update checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_updates.size() == 0) begin
            $error("drive update with none pending: phase %0d", rsp_if.motion_phase);
            failures++;
         end else begin
            next_update = pending_updates.pop_front();
            check_field("drive_horiz_dir", next_update.drive_horiz_dir,
                        rsp_if.drive_horiz_dir);
            check_field("drive_horiz_power", next_update.drive_horiz_power,
                        rsp_if.drive_horiz_power);
            check_field("drive_vert_dir", next_update.drive_vert_dir,
                        rsp_if.drive_vert_dir);
            check_field("drive_vert_power", next_update.drive_vert_power,
                        rsp_if.drive_vert_power);
            check_field("motion_phase", next_update.motion_phase, rsp_if.motion_phase);
            updates_checked++;
         end
      end
   end

   // receiver stalls: random bursts, or a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d updates pending", cycle_count,
                  pending_updates.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic test_idle_and_restart();
      send_request(tick_req());
      send_request(command_req(dcss_pkg::DIR_IDLE, 8'd77, dcss_pkg::DIR_IDLE, 8'd66, 8'd9));
      send_request(command_req(2'd1, 8'd255, 2'd2, 8'd1, 8'd2));
      // restart keeps the period of two
      send_request(command_req(2'd1, 8'd128, 2'd2, 8'd3, 8'd0));
      send_request(tick_req());
      send_request(command_req(2'd1, 8'd255, 2'd2, 8'd1, 8'd0));
      send_request(tick_req());
      send_request(tick_req());
      // stopping: other directions ignored, held ones resume
      send_request(command_req(2'd3, 8'd9, 2'd2, 8'd9, 8'd9));
      send_request(command_req(2'd1, 8'd200, 2'd2, 8'd100, 8'd5));
      send_request(command_req(dcss_pkg::DIR_IDLE, 8'd0, dcss_pkg::DIR_IDLE, 8'd0, 8'd0));
   endtask

   task automatic test_stop_extremes();
      set_stop_config(16'd1, 3'd0);
      send_request(tick_req());
      send_request(command_req(2'd3, 8'd255, 2'd3, 8'd255, 8'd255));
      send_request(command_req(dcss_pkg::DIR_IDLE, 8'd255, dcss_pkg::DIR_IDLE, 8'd255,
                               8'd255));
      // interval zero acts as one tick
      set_stop_config(16'd0, 3'd7);
      send_request(command_req(2'd2, 8'd255, 2'd1, 8'd255, 8'd0));
      repeat (9) send_request(tick_req());
      set_stop_config(16'hFFFF, 3'd7);
      send_request(command_req(2'd1, 8'd10, 2'd1, 8'd20, 8'd3));
      send_request(command_req(2'd2, 8'd10, 2'd1, 8'd20, 8'd3));
      send_request(tick_req());
   endtask

   task automatic test_output_backpressure();
      set_stop_config(16'd1, 3'd7);
      idling_on = 1'b0;
      send_request(command_req(2'd1, 8'd100, 2'd1, 8'd200, 8'd255));
      rsp_hold_request = 80;
      repeat (40)
         send_request(command_req(2'd1, 8'($urandom), 2'd1, 8'($urandom), 8'($urandom)));
      wait_for_drain();
      idling_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int n_items, input bit with_idling);
      drive_req_type r;
      int pick;
      idling_on = with_idling;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         r = random_request();
         if (pick < 45) begin
            r.mode = dcss_pkg::MODE_TICK;
         end else if (pick < 92) begin
            if (pick >= 80) begin
               do begin
                  cur_hdir = 2'($urandom);
                  cur_vdir = 2'($urandom);
               end while (cur_hdir == dcss_pkg::DIR_IDLE && cur_vdir == dcss_pkg::DIR_IDLE);
            end
            r.mode       = dcss_pkg::MODE_COMMAND;
            r.horiz_dir  = cur_hdir;
            r.vert_dir   = cur_vdir;
            r.hold_ticks = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 12));
         end
         if ($urandom_range(0, 59) == 0)
            wait_for_drain();
         send_request(r);
      end
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 6; p++) begin
         set_stop_config((p == 0) ? 16'd1 : 16'($urandom_range(0, 4)),
                         3'($urandom_range(0, 7)));
         // last stretch runs without idling
         test_random_traffic(190, p < 5);
      end
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.mode        = dcss_pkg::MODE_COMMAND;
      req_if.horiz_dir   = dcss_pkg::DIR_IDLE;
      req_if.horiz_power = '0;
      req_if.vert_dir    = dcss_pkg::DIR_IDLE;
      req_if.vert_power  = '0;
      req_if.hold_ticks  = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = dcss_pkg::CSR_STOP_INTERVAL;
      csr_if.data        = '0;
      motion_state   = dcss_pkg::PH_IDLE;
      held_hdir      = dcss_pkg::DIR_IDLE;
      held_hpow      = '0;
      held_vdir      = dcss_pkg::DIR_IDLE;
      held_vpow      = '0;
      halvings_done  = '0;
      interval_count = '0;
      wd_armed       = 1'b0;
      wd_count       = '0;
      wd_period      = '0;
      cfg_interval   = dcss_pkg::STOP_INTERVAL_RESET;
      cfg_halvings   = dcss_pkg::STOP_HALVINGS_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_restart();
      test_stop_extremes();
      test_output_backpressure();
      test_random_settings();

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (pending_updates.size() != 0) begin
         $error("%0d drive updates never arrived", pending_updates.size());
         failures++;
      end
      $display("sent %0d requests under %0d stop settings, checked %0d drive updates",
               requests_sent, settings_used + 1, updates_checked);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
